>>> design/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared widths, function codes and control types of the code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // Default configuration of the block.
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  // Fixed field widths of the channels.
  localparam int FUNC_W        = 2;
  localparam int SYMBOL_W      = 8;
  localparam int CODE_BITS_W   = 32;
  localparam int CODE_LENGTH_W = 6;
  localparam int BYTE_W        = 8;
  localparam int TOTAL_W       = 40;

  // Width of the bit accumulator that holds not yet emitted bits.
  localparam int PEND_W  = 7;
  localparam int PCOUNT_W = 3;

  // Function codes of an input item.
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

  // Control of the lookup stage, handed to the packer.
  typedef struct packed {
    logic valid;
    logic flush;
  } s1_ctrl_t;

endpackage

>>> design/hcbp_if.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface hcbp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [hcbp_pkg::FUNC_W-1:0]          func;
  logic [hcbp_pkg::SYMBOL_W-1:0]        symbol;
  logic [hcbp_pkg::CODE_BITS_W-1:0]     code_bits;
  logic [hcbp_pkg::CODE_LENGTH_W-1:0]   code_length;

  modport source (output valid, func, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, func, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_out_if;
  logic                            valid;
  logic                            ready;
  logic [hcbp_pkg::BYTE_W-1:0]     packed_byte;
  logic                            byte_valid;
  logic [hcbp_pkg::TOTAL_W-1:0]    total_bits;
  logic                            is_final;

  modport source (output valid, packed_byte, byte_valid, total_bits, is_final, input ready);
  modport sink   (input valid, packed_byte, byte_valid, total_bits, is_final, output ready);
endinterface

>>> design/hcbp_table.sv
// ----------------------------------------------------------------------------
// Huffman code table
// Code memory with per-entry valid bits and the registered lookup stage.
// ----------------------------------------------------------------------------
module hcbp_table #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT,
  localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32,
  localparam int LEN_W  = $clog2(CODE_W + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic                                 rd_en,
  input  logic [hcbp_pkg::FUNC_W-1:0]          func,
  input  logic [hcbp_pkg::SYMBOL_W-1:0]        symbol,
  input  logic [hcbp_pkg::CODE_BITS_W-1:0]     code_bits,
  input  logic [hcbp_pkg::CODE_LENGTH_W-1:0]   code_length,
  input  logic                                 s1_take,
  output hcbp_pkg::s1_ctrl_t                   s1_ctrl,
  output logic [CODE_W-1:0]                    rd_code,
  output logic [LEN_W-1:0]                     rd_len
);

  localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENTRY_W = CODE_W + LEN_W;

  logic [ENTRY_W-1:0]      mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] entry_vld;
  logic [ENTRY_W-1:0]      rd_entry;
  logic                    rd_hit;
  logic                    hit;
  logic [ADDR_W-1:0]       addr;
  logic [LEN_W-1:0]        wr_len;

  assign hit  = ({1'b0, symbol} < (hcbp_pkg::SYMBOL_W + 1)'(SYMBOL_COUNT));
  assign addr = symbol[ADDR_W-1:0];

  // Lengths beyond the code width saturate.
  assign wr_len = (32'(code_length) > 32'(CODE_W)) ? LEN_W'(CODE_W)
                                                    : LEN_W'(code_length);

  always_ff @(posedge clk) begin
    if (wr_en && hit) begin
      mem[addr] <= {code_bits[CODE_W-1:0], wr_len};
    end
    if (rd_en) begin
      rd_entry <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr_en && hit) begin
      entry_vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
      rd_hit  <= 1'b0;
    end else if (rd_en) begin
      s1_ctrl.valid <= 1'b1;
      s1_ctrl.flush <= (func == hcbp_pkg::FUNC_FLUSH);
      rd_hit        <= hit && entry_vld[addr];
    end else if (s1_take) begin
      s1_ctrl.valid <= 1'b0;
    end
  end

  // An entry never written reads as length zero.
  assign rd_code = rd_entry[ENTRY_W-1:LEN_W];
  assign rd_len  = rd_hit ? rd_entry[LEN_W-1:0] : '0;

endmodule

>>> design/hcbp_packer.sv
// ----------------------------------------------------------------------------
// Huffman bit packer
// Appends codes to the bit accumulator and sends completed bytes one a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module hcbp_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
  localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32,
  localparam int LEN_W  = $clog2(CODE_W + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  hcbp_pkg::s1_ctrl_t s1_ctrl,
  input  logic [CODE_W-1:0]  rd_code,
  input  logic [LEN_W-1:0]   rd_len,
  output logic               s1_take,
  hcbp_out_if.source         out_ch
);

  localparam int ACC_W     = CODE_W + hcbp_pkg::PEND_W;
  localparam int MAX_BYTES = ACC_W / 8;
  localparam int BUF_W     = 8 * (MAX_BYTES + 1);
  localparam int TOT_W     = $clog2(ACC_W + 1);
  localparam int SH_W      = $clog2(BUF_W + 1);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  logic [hcbp_pkg::PEND_W-1:0]   pending;
  logic [hcbp_pkg::PCOUNT_W-1:0] pcount;
  logic [hcbp_pkg::TOTAL_W-1:0]  bit_total;

  logic [hcbp_pkg::BYTE_W-1:0]   bytes [MAX_BYTES];
  logic [CNT_W-1:0]              bcnt;
  logic                          bfinal;
  logic                          bflag;
  logic [hcbp_pkg::TOTAL_W-1:0]  btotal;

  logic                          free;
  logic [CODE_W-1:0]             cmask;
  logic [ACC_W-1:0]              acc;
  logic [TOT_W-1:0]              total;
  logic [BUF_W-1:0]              aligned;
  logic [2:0]                    rem;
  logic [hcbp_pkg::PEND_W-1:0]   pend_next;
  logic [hcbp_pkg::BYTE_W-1:0]   flush_byte;

  assign free    = (bcnt == '0) || ((bcnt == CNT_W'(1)) && out_ch.ready);
  assign s1_take = s1_ctrl.valid && free;

  // New bits go below the pending ones; the whole run is then aligned to the
  // top of the byte window so that byte k sits at a fixed place.
  assign cmask     = ~({CODE_W{1'b1}} << rd_len);
  assign acc       = (ACC_W'(pending) << rd_len) | ACC_W'(rd_code & cmask);
  assign total     = TOT_W'(pcount) + TOT_W'(rd_len);
  assign aligned   = BUF_W'(acc) << (SH_W'(BUF_W) - SH_W'(total));
  assign rem       = total[2:0];
  assign pend_next = hcbp_pkg::PEND_W'(acc) & ~({hcbp_pkg::PEND_W{1'b1}} << rem);
  assign flush_byte = {1'b0, pending} << (4'd8 - 4'(pcount));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      pcount    <= '0;
      bit_total <= '0;
      bcnt      <= '0;
      bfinal    <= 1'b0;
    end else if (s1_take) begin
      if (s1_ctrl.flush) begin
        bcnt      <= CNT_W'(1);
        bfinal    <= 1'b1;
        pending   <= '0;
        pcount    <= '0;
        bit_total <= '0;
      end else begin
        bcnt      <= CNT_W'(total >> 3);
        bfinal    <= 1'b0;
        pending   <= pend_next;
        pcount    <= rem;
        bit_total <= bit_total + hcbp_pkg::TOTAL_W'(rd_len);
      end
    end else if (out_ch.valid && out_ch.ready) begin
      bcnt <= bcnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      if (s1_ctrl.flush) begin
        bytes[0] <= flush_byte;
        bflag    <= (pcount != '0);
        btotal   <= bit_total;
      end else begin
        for (int k = 0; k < MAX_BYTES; k++) begin
          bytes[k] <= aligned[BUF_W-1-8*k -: 8];
        end
      end
    end else if (out_ch.valid && out_ch.ready) begin
      for (int k = 0; k < MAX_BYTES - 1; k++) begin
        bytes[k] <= bytes[k+1];
      end
      bytes[MAX_BYTES-1] <= '0;
    end
  end

  assign out_ch.valid       = (bcnt != '0);
  assign out_ch.packed_byte = bytes[0];
  assign out_ch.byte_valid  = bfinal ? bflag : 1'b1;
  assign out_ch.total_bits  = bfinal ? btotal : '0;
  assign out_ch.is_final    = bfinal;

endmodule

>>> design/huffman_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Code table lookup and MSB-first byte packing of Huffman codes.
// ----------------------------------------------------------------------------
// Usage: input items arrive on in_ch and result items leave on out_ch, both
// valid/ready channels. A write item loads one table entry and gives no
// result. An encode item gives one result per byte it completes (0 to 4).
// A flush item gives exactly one result with is_final set, the padded last
// byte if any bits were pending, and the bit count since the previous flush.
// An accepted item is looked up as it is accepted, enters the packer once the
// packer is free, and its first result is shown from then on. Throughput:
// one item per cycle while each item gives at most one result and the
// receiver is ready; an item giving more bytes holds the output stage until
// all are sent, since the output stage sends one byte a cycle while ready.
// Reset clears the accumulator, the bit count and every table entry at once
// through per-entry valid bits; there is no clearing pass. When the receiver
// stalls, the current result holds and the lookup stage fills, after which
// in_ch.ready drops.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  hcbp_in_if.sink     in_ch,
  hcbp_out_if.source  out_ch
);

  localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int LEN_W  = $clog2(CODE_W + 1);

  hcbp_pkg::s1_ctrl_t  s1_ctrl;
  logic [CODE_W-1:0]   rd_code;
  logic [LEN_W-1:0]    rd_len;
  logic                s1_take;
  logic                in_fire;
  logic                wr_en;
  logic                rd_en;

  assign in_ch.ready = !s1_ctrl.valid || s1_take;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign wr_en       = in_fire && (in_ch.func == hcbp_pkg::FUNC_WRITE);
  assign rd_en       = in_fire && ((in_ch.func == hcbp_pkg::FUNC_ENCODE) ||
                                   (in_ch.func == hcbp_pkg::FUNC_FLUSH));

  hcbp_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .rd_en       (rd_en),
    .func        (in_ch.func),
    .symbol      (in_ch.symbol),
    .code_bits   (in_ch.code_bits),
    .code_length (in_ch.code_length),
    .s1_take     (s1_take),
    .s1_ctrl     (s1_ctrl),
    .rd_code     (rd_code),
    .rd_len      (rd_len)
  );

  hcbp_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_packer (
    .clk     (clk),
    .rst     (rst),
    .s1_ctrl (s1_ctrl),
    .rd_code (rd_code),
    .rd_len  (rd_len),
    .s1_take (s1_take),
    .out_ch  (out_ch)
  );

  // The lookup stage empties once its item moves on and nothing replaces it.
  a_s1_drain: assert property (@(posedge clk) disable iff (rst)
    s1_take && !rd_en |=> !s1_ctrl.valid)
    else $error("lookup stage kept an item that the packer took");

  // A write item never occupies the lookup stage.
  a_write_bypass: assert property (@(posedge clk) disable iff (rst)
    !s1_ctrl.valid && wr_en |=> !s1_ctrl.valid)
    else $error("write item entered the lookup stage");

  // Encode results always carry a byte.
  a_encode_byte: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.is_final |-> out_ch.byte_valid)
    else $error("encode result without a byte");

  // The bit count is shown only on a flush result.
  a_total_final: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.is_final |-> out_ch.total_bits == '0)
    else $error("bit count on a non-final result");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman code bit packer testbench
// Sends table writes, symbol encodes, flushes and unused function codes into
// the packer, predicts the packed bytes and flush reports of every accepted
// item, and checks each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import hcbp_pkg::*;

  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic [SYMBOL_W-1:0]      symbol;
    logic [CODE_BITS_W-1:0]   code_bits;
    logic [CODE_LENGTH_W-1:0] code_length;
  } packer_cmd_t;

  typedef struct {
    logic [BYTE_W-1:0]  packed_byte;
    logic               byte_valid;
    logic [TOTAL_W-1:0] total_bits;
    logic               is_final;
  } packed_out_t;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CODE_CAP = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W;
  localparam int RANDOM_PER_PHASE = 28;
  localparam int TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  packer_cmd_t cmd_queue[$];
  packer_cmd_t cur_cmd;
  packed_out_t expected_bytes[$];
  int unsigned cmds_queued = 0;
  int unsigned cmds_taken = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          failed = 1'b0;

  // Shadow copy of the code table and the bit accumulator.
  logic [CODE_BITS_W-1:0]   code_tab [SYMBOL_COUNT];
  logic [CODE_LENGTH_W-1:0] len_tab [SYMBOL_COUNT];
  logic [PEND_W-1:0]        acc_bits = '0;
  int unsigned              acc_count = 0;
  logic [TOTAL_W-1:0]       bit_count = '0;

  // Symbols the stimulus has written, so that most encodes hit a loaded entry.
  logic [SYMBOL_W-1:0] loaded_syms[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic pack_item(input packer_cmd_t cmd);
    int unsigned len;
    logic [BYTE_W-1:0] acc;
    packed_out_t res;
    case (cmd.func)
      FUNC_WRITE: begin
        if (cmd.symbol < SYMBOL_COUNT) begin
          code_tab[cmd.symbol] = cmd.code_bits;
          len_tab[cmd.symbol] = (cmd.code_length > CODE_CAP) ? CODE_LENGTH_W'(CODE_CAP)
                                                              : cmd.code_length;
        end
      end
      FUNC_ENCODE: begin
        if (cmd.symbol < SYMBOL_COUNT) begin
          len = len_tab[cmd.symbol];
          for (int i = int'(len) - 1; i >= 0; i--) begin
            acc = {acc_bits, code_tab[cmd.symbol][i]};
            if (acc_count == 7) begin
              res.packed_byte = acc;
              res.byte_valid = 1'b1;
              res.total_bits = '0;
              res.is_final = 1'b0;
              expected_bytes.push_back(res);
              acc_bits = '0;
              acc_count = 0;
            end else begin
              acc_bits = acc[PEND_W-1:0];
              acc_count++;
            end
          end
          bit_count = bit_count + TOTAL_W'(len);
        end
      end
      FUNC_FLUSH: begin
        // Pending bits move up to the MSB end and the rest is zero padding.
        acc = {1'b0, acc_bits};
        res.packed_byte = (acc_count == 0) ? '0 : acc << (BYTE_W - acc_count);
        res.byte_valid = (acc_count != 0);
        res.total_bits = bit_count;
        res.is_final = 1'b1;
        expected_bytes.push_back(res);
        acc_bits = '0;
        acc_count = 0;
        bit_count = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [SYMBOL_W-1:0] symbol,
                           input logic [CODE_BITS_W-1:0] code_bits,
                           input logic [CODE_LENGTH_W-1:0] code_length);
    packer_cmd_t cmd;
    cmd.func = func;
    cmd.symbol = symbol;
    cmd.code_bits = code_bits;
    cmd.code_length = code_length;
    cmd_queue.push_back(cmd);
    cmds_queued++;
  endtask

  task automatic add_random_cmd();
    int unsigned pick;
    logic [SYMBOL_W-1:0] sym;
    logic [CODE_LENGTH_W-1:0] len;
    pick = $urandom_range(99, 0);
    if (pick < 12) begin
      if ($urandom_range(2, 0) == 0 && loaded_syms.size() > 0) begin
        sym = loaded_syms[$urandom_range(loaded_syms.size() - 1, 0)];
      end else begin
        sym = SYMBOL_W'($urandom_range(255, 0));
      end
      case ($urandom_range(9, 0))
        0: len = '0;
        1, 2: len = CODE_LENGTH_W'($urandom_range(63, 33));
        3, 4, 5: len = CODE_LENGTH_W'($urandom_range(32, 11));
        default: len = CODE_LENGTH_W'($urandom_range(10, 1));
      endcase
      queue_cmd(FUNC_WRITE, sym, $urandom(), len);
      loaded_syms.push_back(sym);
    end else if (pick < 82) begin
      if ($urandom_range(99, 0) < 85 && loaded_syms.size() > 0) begin
        sym = loaded_syms[$urandom_range(loaded_syms.size() - 1, 0)];
      end else begin
        sym = SYMBOL_W'($urandom_range(255, 0));
      end
      queue_cmd(FUNC_ENCODE, sym, $urandom(), CODE_LENGTH_W'($urandom_range(63, 0)));
    end else if (pick < 94) begin
      queue_cmd(FUNC_FLUSH, SYMBOL_W'($urandom_range(255, 0)), $urandom(),
                CODE_LENGTH_W'($urandom_range(63, 0)));
    end else begin
      queue_cmd(FUNC_UNUSED, SYMBOL_W'($urandom_range(255, 0)), $urandom(),
                CODE_LENGTH_W'($urandom_range(63, 0)));
    end
  endtask

  task automatic wait_drained();
    while (cmds_taken != cmds_queued || expected_bytes.size() != 0) @(negedge clk);
  endtask

  // Driver: the item on the channel is held until it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pack_item(cur_cmd);
        cmds_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_cmd = cmd_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= cur_cmd.func;
          in_ch.symbol <= cur_cmd.symbol;
          in_ch.code_bits <= cur_cmd.code_bits;
          in_ch.code_length <= cur_cmd.code_length;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Monitor: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    packed_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("result item with no prediction: packed_byte %h is_final %b",
               out_ch.packed_byte, out_ch.is_final);
        failed = 1'b1;
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.packed_byte !== want.packed_byte) begin
          $error("packed_byte: expected %h, got %h", want.packed_byte, out_ch.packed_byte);
          failed = 1'b1;
        end
        if (out_ch.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %b, got %b", want.byte_valid, out_ch.byte_valid);
          failed = 1'b1;
        end
        if (out_ch.total_bits !== want.total_bits) begin
          $error("total_bits: expected %0d, got %0d", want.total_bits, out_ch.total_bits);
          failed = 1'b1;
        end
        if (out_ch.is_final !== want.is_final) begin
          $error("is_final: expected %b, got %b", want.is_final, out_ch.is_final);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_WRITE;
    in_ch.symbol = '0;
    in_ch.code_bits = '0;
    in_ch.code_length = '0;
    out_ch.ready = 1'b0;
    foreach (len_tab[s]) begin
      len_tab[s] = '0;
      code_tab[s] = '0;
    end

    // Empty table and empty accumulator first.
    queue_cmd(FUNC_ENCODE, 8'h00, 32'h0, 6'd0);
    queue_cmd(FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
    // Full-width code, an over-long length, a one-bit code with junk above it.
    queue_cmd(FUNC_WRITE, 8'h00, 32'hFFFF_FFFF, 6'd32);
    queue_cmd(FUNC_WRITE, 8'hFF, 32'h0000_0000, 6'd63);
    queue_cmd(FUNC_WRITE, 8'h55, 32'hFFFF_FFFF, 6'd1);
    queue_cmd(FUNC_WRITE, 8'hAA, 32'h0000_0016, 6'd5);
    queue_cmd(FUNC_WRITE, 8'h01, 32'hA5A5_A5A5, 6'd33);
    // The unused function code must leave the table alone.
    queue_cmd(FUNC_UNUSED, 8'h01, 32'h1234_5678, 6'h3F);
    queue_cmd(FUNC_ENCODE, 8'h00, 32'h0, 6'd0);
    queue_cmd(FUNC_ENCODE, 8'h55, 32'h0, 6'd0);
    queue_cmd(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0);
    queue_cmd(FUNC_ENCODE, 8'hAA, 32'h0, 6'd0);
    queue_cmd(FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
    queue_cmd(FUNC_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    queue_cmd(FUNC_ENCODE, 8'h01, 32'h0, 6'd0);
    queue_cmd(FUNC_ENCODE, 8'hAA, 32'h0, 6'd0);
    // A zero length turns a loaded symbol back into one that adds nothing.
    queue_cmd(FUNC_WRITE, 8'h55, 32'hFFFF_FFFF, 6'd0);
    queue_cmd(FUNC_ENCODE, 8'h55, 32'h0, 6'd0);
    queue_cmd(FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
    // The table survives a flush.
    queue_cmd(FUNC_ENCODE, 8'h01, 32'h0, 6'd0);
    queue_cmd(FUNC_ENCODE, 8'hAA, 32'h0, 6'd0);
    queue_cmd(FUNC_FLUSH, 8'h00, 32'h0, 6'd0);
    loaded_syms = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct = 36;
          recv_stall_pct = 36;
        end
      endcase
      repeat (RANDOM_PER_PHASE) add_random_cmd();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failed || expected_bytes.size() != 0) begin
      $display("huffman_code_bit_packer_top regression: fail");
    end else begin
      $display("huffman_code_bit_packer_top regression: pass");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("huffman_code_bit_packer_top regression: fail");
    $finish;
  end

endmodule
